@@ hw/rtl/ttsi_pkg.sv @@
// ttsi_pkg: shared constants for the tracking table search and interpolation block.
// Used by ttsi_div and tracking_table_search_interp; depends on nothing.
package ttsi_pkg;

   localparam int TBL_DEPTH = 2048;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);

   localparam int DATA_W    = 32;
   localparam int STEP_W    = 10;
   localparam int OFFS_W    = 16;
   localparam int MAXI_W    = 11;
   localparam int ADDR_W    = 11;
   localparam int FRAC_W    = 8;

   // fraction quotient is below step_size * 2^FRAC_W
   localparam int QUO_W     = STEP_W + FRAC_W;
   localparam int PROD_W    = DATA_W + STEP_W;
   localparam int DIV_STEPS = 2;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FALLING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXIDX  = 2'd3;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

endpackage

@@ hw/rtl/ttsi_div.sv @@
// ttsi_div: restoring divider for the interpolation fraction, DIV_STEPS bits a cycle.
// Depends on ttsi_pkg.
module ttsi_div import ttsi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DATA_W-1:0]   rem_init,
   input  logic [QUO_W-1:0]    low_init,
   input  logic [DATA_W-1:0]   den,
   output logic                done,
   output logic [QUO_W-1:0]    quo
);

   localparam int ITERS = QUO_W / DIV_STEPS;
   localparam int CNT_W = $clog2(ITERS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]    low_ff, low_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;

   logic [DATA_W-1:0]   r_step;
   logic [QUO_W-1:0]    l_step;
   logic [QUO_W-1:0]    q_step;
   logic [DATA_W:0]     trial;

   // remainder stays below den, so a trial fits DATA_W+1 bits
   always_comb begin
      r_step = rem_ff;
      l_step = low_ff;
      q_step = quo_ff;
      trial  = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         trial  = {r_step, l_step[QUO_W-1]};
         l_step = {l_step[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            r_step = DATA_W'(trial - {1'b0, den});
            q_step = {q_step[QUO_W-2:0], 1'b1};
         end else begin
            r_step = trial[DATA_W-1:0];
            q_step = {q_step[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ITERS);
         rem_in  = rem_init;
         low_in  = low_init;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = r_step;
         low_in = l_step;
         quo_in = q_step;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ hw/rtl/tracking_table_search_interp.sv @@
// tracking_table_search_interp: sensor linearizer, calibration table walk plus interpolation.
// Depends on ttsi_pkg and ttsi_div.
//
// One item at a time. A table write (op 0) completes at its accept edge and leaves busy low,
// so the next item may follow in the very next cycle. A convert (op 1) raises busy; it walks
// the table from where the last convert stopped, one read per index move, then passes ST_DIFF
// and ST_MUL. When the sample lands on an entry or is clamped it goes on to ST_SUM; when it
// is interpolated, ST_DLOAD starts a 2-bit-per-cycle divider pass in ST_DIV for the fraction
// before ST_SUM. ST_OUT follows. The result sits on the rsp_ ports for exactly one cycle
// marked by rsp_valid and cannot be held off; busy drops the cycle after.
module tracking_table_search_interp import ttsi_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // item channel
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_op,
   input  logic [ADDR_W-1:0]          req_entry_address,
   input  logic signed [DATA_W-1:0]   req_entry_value,
   input  logic signed [DATA_W-1:0]   req_sample,
   // result channel
   output logic                       rsp_valid,
   output logic signed [DATA_W-1:0]   rsp_result_value,
   output logic [ADDR_W-1:0]          rsp_found_index,
   output logic                       rsp_exact_hit,
   output logic                       rsp_saturated,
   // register writes
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_DIFF  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DLOAD = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_SUM   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   // what the read data in a walk cycle means
   localparam logic [1:0] MODE_CUR  = 2'd0;  // entry at idx
   localparam logic [1:0] MODE_UP   = 2'd1;  // entry at idx, just stepped up
   localparam logic [1:0] MODE_DOWN = 2'd2;  // entry at idx, just stepped down
   localparam logic [1:0] MODE_TOP  = 2'd3;  // entry above the top index

   localparam int TOP_LIMIT = TBL_DEPTH - 2;

   function automatic logic above_f(input logic fall,
                                    input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
      return fall ? (a < b) : (a > b);
   endfunction

   // configuration
   logic                     falling_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [OFFS_W-1:0] offset_ff;
   logic [MAXI_W-1:0]        maxidx_ff;

   // control
   logic [2:0]               state_ff, state_in;
   logic [1:0]               mode_ff, mode_in;
   logic [TBL_AW-1:0]        idx_ff, idx_in;
   logic [TBL_AW-1:0]        track_ff;
   logic                     interp_ff, sat_ff;

   // payload
   logic signed [DATA_W-1:0] sample_ff, prev_ff, lo_ff, hi_ff;
   logic [DATA_W-1:0]        num_ff, den_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic signed [DATA_W-1:0] base_ff;
   logic signed [DATA_W-1:0] result_ff;

   // table memory
   logic signed [DATA_W-1:0] mem [TBL_DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;
   logic [TBL_AW-1:0]        rd_addr;
   logic                     mem_we;

   logic                     accept;
   logic [TBL_AW-1:0]        top_idx, start_idx;

   // walk decision
   logic                     s_above, t_above, eval_cur;
   logic                     walk_done, fin_interp, fin_sat;
   logic [TBL_AW-1:0]        fin_idx;
   logic signed [DATA_W-1:0] fin_lo, fin_hi;

   logic signed [DATA_W:0]   num_wide, den_wide;

   logic                     div_start, div_done;
   logic [QUO_W-1:0]         div_quo;

   assign accept = start && !busy;
   assign mem_we = accept && (req_op == OP_WRITE) &&
                   (32'(req_entry_address) < 32'(TBL_DEPTH));

   // walk may not pass the top index, and the entry above it must exist
   assign top_idx   = (32'(maxidx_ff) > 32'(TOP_LIMIT)) ? TBL_AW'(TOP_LIMIT)
                                                         : TBL_AW'(maxidx_ff);
   assign start_idx = (track_ff > top_idx) ? top_idx : track_ff;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         falling_ff <= 1'b0;
         step_ff    <= STEP_W'(100);
         offset_ff  <= OFFS_W'(-20900);
         maxidx_ff  <= MAXI_W'(1409);
      end else if (csr_we) begin
         case (csr_index)
            CSR_FALLING: falling_ff <= csr_wdata[0];
            CSR_STEP:    step_ff    <= csr_wdata[STEP_W-1:0];
            CSR_OFFSET:  offset_ff  <= csr_wdata[OFFS_W-1:0];
            CSR_MAXIDX:  maxidx_ff  <= csr_wdata[MAXI_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- table memory, one write and one read a cycle ----------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[TBL_AW'(req_entry_address)] <= req_entry_value;
      end
      rdata_ff <= mem[rd_addr];
   end

   // ---------------- walk and sequencing ----------------
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      idx_in     = idx_ff;
      rd_addr    = start_idx;
      s_above    = above_f(falling_ff, sample_ff, rdata_ff);
      t_above    = above_f(falling_ff, rdata_ff, sample_ff);
      eval_cur   = 1'b0;
      walk_done  = 1'b0;
      fin_interp = 1'b0;
      fin_sat    = 1'b0;
      fin_idx    = idx_ff;
      fin_lo     = prev_ff;
      fin_hi     = rdata_ff;
      div_start  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_CONVERT)) begin
               idx_in   = start_idx;
               mode_in  = MODE_CUR;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            eval_cur = 1'b1;
            case (mode_ff)
               MODE_TOP: begin
                  eval_cur  = 1'b0;
                  walk_done = 1'b1;
                  if (t_above) begin
                     fin_interp = 1'b1;
                  end else begin
                     fin_sat = 1'b1;
                  end
               end
               MODE_UP: begin
                  // overshot: segment is the one below
                  if (t_above) begin
                     eval_cur   = 1'b0;
                     walk_done  = 1'b1;
                     fin_interp = 1'b1;
                     fin_idx    = idx_ff - TBL_AW'(1);
                  end
               end
               MODE_DOWN: begin
                  if (s_above) begin
                     eval_cur   = 1'b0;
                     walk_done  = 1'b1;
                     fin_interp = 1'b1;
                     fin_lo     = rdata_ff;
                     fin_hi     = prev_ff;
                  end
               end
               default: ;
            endcase

            if (eval_cur) begin
               if (s_above) begin
                  rd_addr = idx_ff + TBL_AW'(1);
                  if (idx_ff >= top_idx) begin
                     mode_in = MODE_TOP;
                  end else begin
                     idx_in  = idx_ff + TBL_AW'(1);
                     mode_in = MODE_UP;
                  end
               end else if (t_above) begin
                  if (idx_ff == '0) begin
                     walk_done = 1'b1;
                     fin_sat   = 1'b1;
                  end else begin
                     rd_addr = idx_ff - TBL_AW'(1);
                     idx_in  = idx_ff - TBL_AW'(1);
                     mode_in = MODE_DOWN;
                  end
               end else begin
                  walk_done = 1'b1;   // sample equals the entry
               end
            end

            if (walk_done) begin
               idx_in   = fin_idx;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = interp_ff ? ST_DLOAD : ST_SUM;
         ST_DLOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:   state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mode_ff   <= MODE_CUR;
         idx_ff    <= '0;
         track_ff  <= '0;
         interp_ff <= 1'b0;
         sat_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         idx_ff   <= idx_in;
         if ((state_ff == ST_WALK) && walk_done) begin
            track_ff  <= fin_idx;
            interp_ff <= fin_interp;
            sat_ff    <= fin_sat;
         end
      end
   end

   // ---------------- datapath ----------------
   // rising: lo < s < hi, falling: lo > s > hi; both differences are positive here
   assign num_wide = falling_ff ? ({lo_ff[DATA_W-1], lo_ff} - {sample_ff[DATA_W-1], sample_ff})
                                : ({sample_ff[DATA_W-1], sample_ff} - {lo_ff[DATA_W-1], lo_ff});
   assign den_wide = falling_ff ? ({lo_ff[DATA_W-1], lo_ff} - {hi_ff[DATA_W-1], hi_ff})
                                : ({hi_ff[DATA_W-1], hi_ff} - {lo_ff[DATA_W-1], lo_ff});

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && accept) begin
         sample_ff <= req_sample;
      end
      if (state_ff == ST_WALK) begin
         prev_ff <= rdata_ff;
         if (walk_done) begin
            lo_ff <= fin_lo;
            hi_ff <= fin_hi;
         end
      end
      if (state_ff == ST_DIFF) begin
         num_ff <= num_wide[DATA_W-1:0];
         den_ff <= den_wide[DATA_W-1:0];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(num_ff * step_ff);
         base_ff <= DATA_W'(idx_ff * step_ff) + DATA_W'(offset_ff);
      end
      if (state_ff == ST_SUM) begin
         result_ff <= (base_ff <<< FRAC_W) +
                      (interp_ff ? DATA_W'(div_quo) : '0);
      end
   end

   // fraction = num * step * 2^FRAC_W / den; top part of the dividend is already below den
   ttsi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (prod_ff[PROD_W-1:STEP_W]),
      .low_init ({prod_ff[STEP_W-1:0], {FRAC_W{1'b0}}}),
      .den      (den_ff),
      .done     (div_done),
      .quo      (div_quo)
   );

   // ---------------- ports ----------------
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_OUT);
   assign rsp_result_value = result_ff;
   assign rsp_found_index  = ADDR_W'(track_ff);
   assign rsp_exact_hit    = !interp_ff;
   assign rsp_saturated    = sat_ff;

   // ---------------- assertions ----------------
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_convert_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_CONVERT)) |=> busy)
      else $error("convert item accepted without going busy");

   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_WRITE)) |=> !busy)
      else $error("table write made the block busy");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff <= top_idx))
      else $error("walk index beyond top index");

   a_sat_is_exact: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> rsp_exact_hit)
      else $error("clamped result carries a fraction");

endmodule
